FILE: rtl/fpid_pkg.sv
`default_nettype none

package fpid_pkg;

    localparam int LEVELS         = 7;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int CELLS          = LEVELS * LEVELS;
    localparam int LVL_W          = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CELL_W         = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NUM_TABLES     = 3;

    localparam int ERR_CLAMP  = 300;
    localparam int ERR_OFFSET = 350;
    localparam int ERR_STEP   = 100;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ACTION_W  = 2;
    localparam int TSEL_W    = 2;
    localparam int TIDX_W    = 6;
    localparam int VALUE_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int DRIVE_W   = 16;
    localparam int RAW_W     = 26;

    localparam int ERR_W  = VALUE_W + 1;
    localparam int CHG_W  = ERR_W + 1;
    localparam int SUM_W  = 16;
    localparam int EA_W   = CHG_W;
    localparam int GAIN_W = 16;
    localparam int PP_W   = ERR_W + GAIN_W;
    localparam int PI_W   = SUM_W + GAIN_W;
    localparam int PD_W   = CHG_W + GAIN_W;
    localparam int ACC_W  = PD_W + 2;

    localparam logic signed [GAIN_W-1:0]  KP_RESET    = GAIN_W'(1664);
    localparam logic signed [GAIN_W-1:0]  KI_RESET    = GAIN_W'(205);
    localparam logic signed [GAIN_W-1:0]  KD_RESET    = GAIN_W'(0);
    localparam logic        [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20000);
    localparam logic        [DRIVE_W-1:0] DMAX_RESET  = DRIVE_W'(9000);
    localparam logic        [DRIVE_W-1:0] DMIN_RESET  = DRIVE_W'(0);

    typedef enum logic [ACTION_W-1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_INIT  = 2'd2
    } action_t;

    typedef enum logic [TSEL_W-1:0] {
        TSEL_KP = 2'd0,
        TSEL_KI = 2'd1,
        TSEL_KD = 2'd2
    } table_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_START  = 3'd0,
        CFG_KI_START  = 3'd1,
        CFG_KD_START  = 3'd2,
        CFG_INT_LIMIT = 3'd3,
        CFG_DRIVE_MAX = 3'd4,
        CFG_DRIVE_MIN = 3'd5
    } cfg_index_t;

    // clamp to the error window, offset, then count the level thresholds passed
    function automatic logic [LVL_W-1:0] level_of(input logic signed [CHG_W-1:0] v);
        logic signed [CHG_W-1:0] c;
        int lv;
        c = v;
        if (c > ERR_CLAMP)
        begin
            c = CHG_W'(ERR_CLAMP);
        end
        if (c < -ERR_CLAMP)
        begin
            c = CHG_W'(-ERR_CLAMP);
        end
        lv = 0;
        for (int k = 1; k < LEVELS; k++)
        begin
            if (int'(c) + ERR_OFFSET >= k * ERR_STEP)
            begin
                lv = k;
            end
        end
        return LVL_W'(lv);
    endfunction

    function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [GAIN_W:0] v);
        logic signed [GAIN_W:0] hi;
        logic signed [GAIN_W:0] lo;
        hi = {2'b00, {(GAIN_W-1){1'b1}}};
        lo = {2'b11, {(GAIN_W-1){1'b0}}};
        if (v > hi)
        begin
            return hi[GAIN_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[GAIN_W-1:0];
        end
        return v[GAIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fuzzy_pid_controller_unit.sv
`default_nettype none

// Fuzzy self-tuning positional PID.
// Input channel (in_valid/in_stall) carries one item per transfer: a control
// step, a delta table write or an init. Each item gives exactly one result on
// the output channel (out_valid/out_stall): drive and raw_output, both zero for
// anything but a control step.
// Pipeline: input register, table read and history update, gain update,
// multiply, sum/shift/clamp into the output register. One item per cycle is
// sustained while out_stall stays low, since the error history and the gains
// each close their update within a single stage.
// The pipeline collapses bubbles: while a result waits under out_stall, new
// items keep entering until every stage holds one, then in_stall rises.
// Reset clears all stages, loads the register reset values and the start
// gains, clears the error history and marks every table entry as zero.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// expected only while the pipeline is empty.

module fuzzy_pid_controller_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [fpid_pkg::ACTION_W-1:0]          action,
    input  logic signed [fpid_pkg::VALUE_W-1:0]    setpoint,
    input  logic signed [fpid_pkg::VALUE_W-1:0]    measured,
    input  logic [fpid_pkg::TSEL_W-1:0]            table_select,
    input  logic [fpid_pkg::TIDX_W-1:0]            table_index,
    input  logic signed [fpid_pkg::VALUE_W-1:0]    table_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [fpid_pkg::DRIVE_W-1:0]           drive,
    output logic signed [fpid_pkg::RAW_W-1:0]      raw_output,
    input  logic                                   cfg_we,
    input  logic [fpid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fpid_pkg::CFG_W-1:0]             cfg_data
);

    import fpid_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0]  kp_start_reg;
    logic signed [GAIN_W-1:0]  ki_start_reg;
    logic signed [GAIN_W-1:0]  kd_start_reg;
    logic        [LIMIT_W-1:0] ilimit_reg;
    logic        [DRIVE_W-1:0] drive_max_reg;
    logic        [DRIVE_W-1:0] drive_min_reg;

    // controller state
    logic signed [GAIN_W-1:0] gain_reg [NUM_TABLES];
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [SUM_W-1:0]  esum_reg;
    logic        [CELLS-1:0]  tvalid_reg [NUM_TABLES];

    // stage 1: input register
    logic                      v1_reg;
    logic                      v1_next;
    logic [ACTION_W-1:0]       act1_reg;
    logic signed [VALUE_W-1:0] sp1_reg;
    logic signed [VALUE_W-1:0] ms1_reg;
    logic [TSEL_W-1:0]         tsel1_reg;
    logic [TIDX_W-1:0]         tidx1_reg;
    logic signed [VALUE_W-1:0] tval1_reg;

    // stage 2: table data
    logic                      v2_reg;
    logic                      v2_next;
    logic [ACTION_W-1:0]       act2_reg;
    logic signed [ERR_W-1:0]   err2_reg;
    logic signed [CHG_W-1:0]   chg2_reg;
    logic signed [SUM_W-1:0]   esum2_reg;
    logic [NUM_TABLES-1:0]     dvld2_reg;

    // stage 3: gains updated
    logic                      v3_reg;
    logic                      v3_next;
    logic                      step3_reg;
    logic signed [ERR_W-1:0]   err3_reg;
    logic signed [CHG_W-1:0]   chg3_reg;
    logic signed [SUM_W-1:0]   esum3_reg;

    // stage 4: products
    logic                      v4_reg;
    logic                      v4_next;
    logic                      step4_reg;
    logic signed [PP_W-1:0]    pp4_reg;
    logic signed [PI_W-1:0]    pi4_reg;
    logic signed [PD_W-1:0]    pd4_reg;

    // output register
    logic                      ov_reg;
    logic                      ov_next;
    logic [DRIVE_W-1:0]        drive_reg;
    logic signed [RAW_W-1:0]   raw_reg;

    logic accept;
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    // stage 1 logic
    logic signed [ERR_W-1:0]  err1;
    logic signed [CHG_W-1:0]  chg1;
    logic [CELL_W-1:0]        cell1;
    logic signed [EA_W-1:0]   acc1;
    logic signed [EA_W-1:0]   lim1;
    logic signed [EA_W-1:0]   accsat1;
    logic signed [SUM_W-1:0]  esum_new1;
    logic                     step1;
    logic                     init1;
    logic                     wr1;
    logic [CELL_W-1:0]        waddr1;
    logic [NUM_TABLES-1:0]    tbl_we;
    logic [VALUE_W-1:0]       tbl_rdata [NUM_TABLES];

    // stage 2 logic
    logic signed [GAIN_W-1:0] delta2 [NUM_TABLES];
    logic signed [GAIN_W-1:0] gain_new2 [NUM_TABLES];
    logic                     step2;
    logic                     init2;

    // stage 4 logic
    logic signed [ACC_W-1:0]  tot4;
    logic signed [ACC_W-1:0]  raw4;
    logic signed [ACC_W-1:0]  dmax4;
    logic signed [ACC_W-1:0]  dmin4;
    logic signed [ACC_W-1:0]  clamp4;

    // handshake and stage advance
    assign adv4   = v4_reg && (!ov_reg || !out_stall);
    assign adv3   = v3_reg && (!v4_reg || adv4);
    assign adv2   = v2_reg && (!v3_reg || adv3);
    assign adv1   = v1_reg && (!v2_reg || adv2);
    assign in_stall = v1_reg && !adv1;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        v1_next = accept || (v1_reg && !adv1);
        v2_next = adv1 || (v2_reg && !adv2);
        v3_next = adv2 || (v3_reg && !adv3);
        v4_next = adv3 || (v4_reg && !adv4);
        ov_next = adv4 || (ov_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            ov_reg <= ov_next;
        end
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_start_reg  <= KP_RESET;
            ki_start_reg  <= KI_RESET;
            kd_start_reg  <= KD_RESET;
            ilimit_reg    <= LIMIT_RESET;
            drive_max_reg <= DMAX_RESET;
            drive_min_reg <= DMIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP_START:  kp_start_reg  <= cfg_data[GAIN_W-1:0];
                CFG_KI_START:  ki_start_reg  <= cfg_data[GAIN_W-1:0];
                CFG_KD_START:  kd_start_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INT_LIMIT: ilimit_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_DRIVE_MAX: drive_max_reg <= cfg_data[DRIVE_W-1:0];
                CFG_DRIVE_MIN: drive_min_reg <= cfg_data[DRIVE_W-1:0];
                default:       ;
            endcase
        end
    end

    // stage 1 load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act1_reg  <= action;
            sp1_reg   <= setpoint;
            ms1_reg   <= measured;
            tsel1_reg <= table_select;
            tidx1_reg <= table_index;
            tval1_reg <= table_value;
        end
    end

    // stage 1: error, change, cell, accumulator
    always_comb
    begin
        step1     = (act1_reg == ACT_STEP);
        init1     = (act1_reg == ACT_INIT);
        err1      = ERR_W'(sp1_reg) - ERR_W'(ms1_reg);
        chg1      = CHG_W'(err1) - CHG_W'(prev_err_reg);
        cell1     = CELL_W'(int'(level_of(CHG_W'(err1))) * LEVELS + int'(level_of(chg1)));
        acc1      = EA_W'(esum_reg) + EA_W'(err1);
        lim1      = EA_W'({1'b0, ilimit_reg});
        if (acc1 > lim1)
        begin
            accsat1 = lim1;
        end
        else if (acc1 < -lim1)
        begin
            accsat1 = -lim1;
        end
        else
        begin
            accsat1 = acc1;
        end
        esum_new1 = accsat1[SUM_W-1:0];
        wr1       = adv1 && (act1_reg == ACT_WRITE) && (32'(tidx1_reg) < CELLS);
        waddr1    = CELL_W'(tidx1_reg);
        tbl_we[TSEL_KP] = wr1 && (tsel1_reg == TSEL_KP);
        tbl_we[TSEL_KI] = wr1 && (tsel1_reg == TSEL_KI);
        tbl_we[TSEL_KD] = wr1 && (tsel1_reg == TSEL_KD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            esum_reg     <= '0;
        end
        else if (adv1 && step1)
        begin
            prev_err_reg <= err1;
            esum_reg     <= esum_new1;
        end
        else if (adv1 && init1)
        begin
            prev_err_reg <= '0;
            esum_reg     <= '0;
        end
    end

    // delta tables: entries read as zero until first written
    for (genvar t = 0; t < NUM_TABLES; t++)
    begin : g_tbl
        fpid_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (CELLS)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we[t]),
            .waddr (waddr1),
            .wdata (tval1_reg),
            .re    (adv1),
            .raddr (cell1),
            .rdata (tbl_rdata[t])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tvalid_reg[t] <= '0;
            end
            else if (tbl_we[t])
            begin
                tvalid_reg[t][waddr1] <= 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld2_reg[t] <= 1'b0;
            end
            else if (adv1)
            begin
                dvld2_reg[t] <= tvalid_reg[t][cell1];
            end
        end

        assign delta2[t]    = dvld2_reg[t] ? tbl_rdata[t] : '0;
        assign gain_new2[t] = sat_gain((GAIN_W + 1)'(gain_reg[t]) + (GAIN_W + 1)'(delta2[t]));
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            act2_reg  <= act1_reg;
            err2_reg  <= err1;
            chg2_reg  <= chg1;
            esum2_reg <= esum_new1;
        end
    end

    // stage 2: gain update
    assign step2 = (act2_reg == ACT_STEP);
    assign init2 = (act2_reg == ACT_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[TSEL_KP] <= KP_RESET;
            gain_reg[TSEL_KI] <= KI_RESET;
            gain_reg[TSEL_KD] <= KD_RESET;
        end
        else if (adv2 && step2)
        begin
            gain_reg[TSEL_KP] <= gain_new2[TSEL_KP];
            gain_reg[TSEL_KI] <= gain_new2[TSEL_KI];
            gain_reg[TSEL_KD] <= gain_new2[TSEL_KD];
        end
        else if (adv2 && init2)
        begin
            gain_reg[TSEL_KP] <= kp_start_reg;
            gain_reg[TSEL_KI] <= ki_start_reg;
            gain_reg[TSEL_KD] <= kd_start_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            step3_reg <= step2;
            err3_reg  <= err2_reg;
            chg3_reg  <= chg2_reg;
            esum3_reg <= esum2_reg;
        end
    end

    // stage 3: products against the gains left by this item
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            step4_reg <= step3_reg;
            pp4_reg   <= PP_W'(err3_reg) * PP_W'(gain_reg[TSEL_KP]);
            pi4_reg   <= PI_W'(esum3_reg) * PI_W'(gain_reg[TSEL_KI]);
            pd4_reg   <= PD_W'(chg3_reg) * PD_W'(gain_reg[TSEL_KD]);
        end
    end

    // stage 4: sum, floor shift, clamp
    always_comb
    begin
        tot4  = ACC_W'(pp4_reg) + ACC_W'(pi4_reg) + ACC_W'(pd4_reg);
        raw4  = tot4 >>> GAIN_FRAC_BITS;
        dmax4 = ACC_W'({1'b0, drive_max_reg});
        dmin4 = ACC_W'({1'b0, drive_min_reg});
        if (raw4 > dmax4)
        begin
            clamp4 = dmax4;
        end
        else if (raw4 < dmin4)
        begin
            clamp4 = dmin4;
        end
        else
        begin
            clamp4 = raw4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            drive_reg <= step4_reg ? clamp4[DRIVE_W-1:0] : '0;
            raw_reg   <= step4_reg ? raw4[RAW_W-1:0] : '0;
        end
    end

    assign out_valid  = ov_reg;
    assign drive      = drive_reg;
    assign raw_output = raw_reg;

    // checks
    logic signed [SUM_W:0] esum_chk;
    logic signed [SUM_W:0] lim_chk;

    assign esum_chk = (SUM_W + 1)'(esum_reg);
    assign lim_chk  = (SUM_W + 1)'({1'b0, ilimit_reg});

    a_esum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        adv1 && step1 |=> (esum_chk <= $past(lim_chk)) && (esum_chk >= -$past(lim_chk)))
        else $error("error sum outside integral limit");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv1 && init1 |=> (prev_err_reg == '0) && (esum_reg == '0))
        else $error("init did not clear error history");

    a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv2 |=> $stable(gain_reg[TSEL_KP]) && $stable(gain_reg[TSEL_KI])
                  && $stable(gain_reg[TSEL_KD]))
        else $error("gains changed without a stage 2 transfer");

    a_drive_window: assert property (@(posedge clk) disable iff (!rst_n)
        adv4 && step4_reg && (drive_min_reg <= drive_max_reg)
        |=> (drive_reg >= $past(drive_min_reg)) && (drive_reg <= $past(drive_max_reg)))
        else $error("drive outside window");

endmodule

`default_nettype wire

FILE: rtl/fpid_ram.sv
`default_nettype none

module fpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 49
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
